>>> hdl/md5sh_pkg.sv
package md5sh_pkg;

   typedef logic [31:0]       word_type;
   typedef logic [3:0][31:0]  chain_type;

   localparam logic [1:0] FN_APPEND        = 2'd0;
   localparam logic [1:0] FN_APPEND_FINISH = 2'd1;
   localparam logic [1:0] FN_FINISH        = 2'd2;
   localparam logic [1:0] FN_ABORT         = 2'd3;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // chain word A sits in lane 0
   localparam chain_type CHAIN_INIT = {32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};

   localparam word_type ROUND_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_MIX,
      CORE_ROT,
      CORE_ADD
   } core_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      RET_APPEND,
      RET_PAD,
      RET_FINAL
   } ret_type;

   // status from the compression unit to the sequencer
   typedef struct packed {
      logic       done;
      logic [3:0] msg_index;
   } stat_type;

   function automatic logic [4:0] rot_amount(input logic [5:0] round);
      logic [4:0] r;
      unique case ({round[5:4], round[1:0]})
         4'd0:  r = 5'd7;
         4'd1:  r = 5'd12;
         4'd2:  r = 5'd17;
         4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;
         4'd5:  r = 5'd9;
         4'd6:  r = 5'd14;
         4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;
         4'd9:  r = 5'd11;
         4'd10: r = 5'd16;
         4'd11: r = 5'd23;
         4'd12: r = 5'd6;
         4'd13: r = 5'd10;
         4'd14: r = 5'd15;
         default: r = 5'd21;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/md5sh_compress.sv
module md5sh_compress (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  md5sh_pkg::chain_type chain_in,
   input  md5sh_pkg::word_type  msg_word,
   output md5sh_pkg::stat_type  stat,
   output md5sh_pkg::chain_type chain_out
);
   import md5sh_pkg::*;

   core_state_type state_ff, state_in;
   logic [5:0]     round_ff, round_in;
   word_type       a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   word_type       sum_ff, sum_in;

   word_type       f_val;
   logic [3:0]     i4;
   logic [3:0]     g_idx;
   logic [63:0]    rot_dbl;
   chain_type      work;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
   end

   assign i4 = round_ff[3:0];

   always_comb begin
      case (round_ff[5:4])
         2'd0: begin
            f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
            g_idx = i4;
         end
         2'd1: begin
            f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
            g_idx = 4'((i4 << 2) + i4 + 4'd1);
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = 4'((i4 << 1) + i4 + 4'd5);
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = 4'((i4 << 3) - i4);
         end
      endcase
   end

   assign rot_dbl = {sum_ff, sum_ff} << rot_amount(round_ff);
   assign work    = {d_ff, c_ff, b_ff, a_ff};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         chain_out[k] = chain_in[k] + work[k];
      end
   end

   assign stat.done      = (state_ff == CORE_ADD);
   assign stat.msg_index = g_idx;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      sum_in   = sum_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (start) begin
               a_in     = chain_in[0];
               b_in     = chain_in[1];
               c_in     = chain_in[2];
               d_in     = chain_in[3];
               round_in = '0;
               state_in = CORE_MIX;
            end
         end
         CORE_MIX: begin
            sum_in   = a_ff + f_val + ROUND_K[round_ff] + msg_word;
            state_in = CORE_ROT;
         end
         CORE_ROT: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_ff + rot_dbl[63:32];
            round_in = round_ff + 6'd1;
            state_in = (round_ff == 6'd63) ? CORE_ADD : CORE_MIX;
         end
         CORE_ADD: begin
            state_in = CORE_IDLE;
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == CORE_IDLE)
      else $error("compression started while busy");

   a_rounds_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == CORE_ADD |-> round_ff == 6'd0)
      else $error("final add reached before 64 rounds");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("done held for more than one cycle");

endmodule

>>> hdl/md5_stream_hasher.sv
// Channel  | Direction | Ports                                   | Moves
// req      | in        | req_valid req_stall req_func req_data_byte | one byte or command
// rsp      | out       | rsp_valid rsp_stall rsp_digest_word      | one digest word
//          |           | rsp_word_index rsp_last_word             |
//
// A byte that does not fill the block is written to the buffer; one that fills it starts a
// compression: the shared round unit runs each of the 64 rounds as a mix and a rotate
// step, then the chaining add. A finish pads one byte a cycle, writes the length as a low
// and a high word, runs one or two compressions if a message is open, then offers four
// words. Reset: initial chaining words, no open message. req_stall is high while a block
// compresses, a finish runs or its words wait; rsp_stall only holds the current word.
module md5_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5sh_pkg::*;

   top_state_type state_ff, state_in;
   ret_type       ret_ff, ret_in;
   chain_type     chain_ff, chain_in;
   logic [5:0]    fill_ff, fill_in;
   logic [60:0]   total_ff, total_in;
   logic          open_ff, open_in;
   logic          pend_ff, pend_in;
   logic [6:0]    pos_ff, pos_in;
   logic          extra_ff, extra_in;
   logic [1:0]    cnt_ff, cnt_in;

   word_type      buf_ff [16];

   logic          wr_en;
   logic [3:0]    wr_idx;
   logic [3:0]    wr_mask;
   word_type      wr_data;

   logic          start;
   stat_type      stat;
   chain_type     chain_sum;
   word_type      msg_word;

   logic [5:0]    fill_cur;
   logic [60:0]   total_cur;
   logic [6:0]    pad_end;

   md5sh_compress u_compress (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .chain_in  (chain_ff),
      .msg_word  (msg_word),
      .stat      (stat),
      .chain_out (chain_sum)
   );

   assign msg_word = buf_ff[stat.msg_index];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < 4; k++) begin
            if (wr_mask[k]) begin
               buf_ff[wr_idx][k*8 +: 8] <= wr_data[k*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= RET_APPEND;
         chain_ff <= CHAIN_INIT;
         fill_ff  <= '0;
         total_ff <= '0;
         open_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         pos_ff   <= '0;
         extra_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         open_ff  <= open_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         extra_ff <= extra_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = chain_ff[cnt_ff];
   assign rsp_word_index  = cnt_ff;
   assign rsp_last_word   = (cnt_ff == 2'd3);

   assign fill_cur  = open_ff ? fill_ff : 6'd0;
   assign total_cur = open_ff ? total_ff : 61'd0;
   assign pad_end   = extra_ff ? 7'd64 : 7'd56;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      chain_in = chain_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      open_in  = open_ff;
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      extra_in = extra_ff;
      cnt_in   = cnt_ff;
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_mask  = '0;
      wr_data  = '0;
      start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FN_ABORT: begin
                     open_in = 1'b0;
                  end
                  FN_FINISH: begin
                     state_in = open_ff ? ST_PAD_MARK : ST_EMIT;
                     cnt_in   = '0;
                  end
                  default: begin
                     // first byte of a message restarts the chain
                     if (!open_ff) begin
                        chain_in = CHAIN_INIT;
                     end
                     wr_en    = 1'b1;
                     wr_idx   = fill_cur[5:2];
                     wr_mask  = 4'b0001 << fill_cur[1:0];
                     wr_data  = {4{req_data_byte}};
                     fill_in  = fill_cur + 6'd1;
                     total_in = total_cur + 61'd1;
                     open_in  = 1'b1;
                     pend_in  = (req_func == FN_APPEND_FINISH);
                     if (fill_cur == 6'd63) begin
                        start    = 1'b1;
                        ret_in   = RET_APPEND;
                        state_in = ST_COMP;
                     end else if (req_func == FN_APPEND_FINISH) begin
                        state_in = ST_PAD_MARK;
                     end
                  end
               endcase
            end
         end
         ST_COMP: begin
            if (stat.done) begin
               chain_in = chain_sum;
               case (ret_ff)
                  RET_APPEND: begin
                     state_in = pend_ff ? ST_PAD_MARK : ST_IDLE;
                  end
                  RET_PAD: begin
                     pos_in   = '0;
                     extra_in = 1'b0;
                     state_in = ST_PAD_ZERO;
                  end
                  default: begin
                     fill_in  = '0;
                     open_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_PAD_MARK: begin
            wr_en    = 1'b1;
            wr_idx   = fill_ff[5:2];
            wr_mask  = 4'b0001 << fill_ff[1:0];
            wr_data  = {4{PAD_BYTE}};
            pos_in   = {1'b0, fill_ff} + 7'd1;
            // no room for the length after the marker: pad out a whole block
            extra_in = (fill_ff >= 6'd56);
            state_in = ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (pos_ff == pad_end) begin
               if (extra_ff) begin
                  start    = 1'b1;
                  ret_in   = RET_PAD;
                  state_in = ST_COMP;
               end else begin
                  state_in = ST_LEN_LO;
               end
            end else begin
               wr_en   = 1'b1;
               wr_idx  = pos_ff[5:2];
               wr_mask = 4'b0001 << pos_ff[1:0];
               wr_data = '0;
               pos_in  = pos_ff + 7'd1;
            end
         end
         ST_LEN_LO: begin
            wr_en    = 1'b1;
            wr_idx   = 4'd14;
            wr_mask  = 4'hF;
            wr_data  = {total_ff[28:0], 3'b000};
            state_in = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            wr_en    = 1'b1;
            wr_idx   = 4'd15;
            wr_mask  = 4'hF;
            wr_data  = total_ff[60:29];
            start    = 1'b1;
            ret_in   = RET_FINAL;
            state_in = ST_COMP;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("digest words continue past the last one");

   a_pad_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD_ZERO |-> pos_ff <= 7'd64)
      else $error("padding ran past the block");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> state_ff == ST_COMP)
      else $error("compression finished while not awaited");

   a_emit_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !open_ff)
      else $error("digest offered with message still open");

endmodule
